>>> rtl/core/epc_pkg.sv
// Shared constants, register map and stage-enable type for the ellipse pixel classifier.
`timescale 1ns / 1ps
`default_nettype none

package epc_pkg;

	localparam int EPC_COORD_WIDTH  = 16;
	localparam int EPC_RADIUS_WIDTH = 10;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam int OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		REG_CENTER_X          = 2'd0,
		REG_CENTER_Y          = 2'd1,
		REG_RADIUS_HORIZONTAL = 2'd2,
		REG_RADIUS_VERTICAL   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

`default_nettype wire

>>> rtl/core/ellipse_pixel_classifier_top.sv
// Top level of the ellipse pixel classifier: config port, pipeline and stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Classifies one pixel per clock, unless m_tready holds the output back, against an
// axis-aligned ellipse set through the APB registers (center_x, center_y, radius_horizontal,
// radius_vertical at 0x0, 0x4, 0x8, 0xC). Each pixel passes through the five pipeline
// stages in order: center offset, magnitude clamp, squaring, scaling by the
// opposite squared radius, and the final compare. The border flag is decided from the
// outward diagonal neighbor alone, which is exact for a filled ellipse. Squared radii
// and their product are registered from the geometry registers, so the geometry must be
// written while no pixel is in flight.

module ellipse_pixel_classifier_top
	import epc_pkg::*;
#(
	parameter int COORD_WIDTH  = EPC_COORD_WIDTH,
	parameter int RADIUS_WIDTH = EPC_RADIUS_WIDTH,
	localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_ADDR_W-1:0]   paddr,
	input  wire logic [APB_DATA_W-1:0]   pwdata,
	output logic      [APB_DATA_W-1:0]   prdata,
	output logic                         pready,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// Fields from bit 0 up: query_x, query_y, zero padding.
	input  wire logic [IN_TDATA_W-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// Fields from bit 0 up: inside_res, border, zero padding.
	output logic      [OUT_TDATA_W-1:0]  m_tdata
);

	localparam int SQ_W = 2 * RADIUS_WIDTH;

	logic signed [COORD_WIDTH-1:0] center_x, center_y;
	logic [RADIUS_WIDTH-1:0]       rx_eff, ry_eff;
	logic [SQ_W-1:0]               rx2, ry2;
	logic [4*RADIUS_WIDTH-1:0]     rr;
	stage_en_t                     en;
	logic                          far_x0, far_x1, far_y0, far_y1;
	logic [SQ_W-1:0]               sq_x0, sq_x1, sq_y0, sq_y1;
	logic                          inside_s5, border_s5;

	assign pready = 1'b1;

	epc_cfg_regs #(
		.COORD_WIDTH (COORD_WIDTH),
		.RADIUS_WIDTH(RADIUS_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.center_x(center_x),
		.center_y(center_y),
		.rx_eff  (rx_eff),
		.ry_eff  (ry_eff),
		.rx2     (rx2),
		.ry2     (ry2),
		.rr      (rr)
	);

	epc_pipe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.en      (en)
	);

	epc_axis #(
		.COORD_WIDTH (COORD_WIDTH),
		.RADIUS_WIDTH(RADIUS_WIDTH)
	) u_axis_x (
		.clk    (clk),
		.en     (en),
		.query  (s_tdata[COORD_WIDTH-1:0]),
		.center (center_x),
		.radius (rx_eff),
		.far0_s3(far_x0),
		.far1_s3(far_x1),
		.sq0_s3 (sq_x0),
		.sq1_s3 (sq_x1)
	);

	epc_axis #(
		.COORD_WIDTH (COORD_WIDTH),
		.RADIUS_WIDTH(RADIUS_WIDTH)
	) u_axis_y (
		.clk    (clk),
		.en     (en),
		.query  (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.center (center_y),
		.radius (ry_eff),
		.far0_s3(far_y0),
		.far1_s3(far_y1),
		.sq0_s3 (sq_y0),
		.sq1_s3 (sq_y1)
	);

	epc_decide #(
		.RADIUS_WIDTH(RADIUS_WIDTH)
	) u_decide (
		.clk      (clk),
		.en       (en),
		.far_x0   (far_x0),
		.far_x1   (far_x1),
		.far_y0   (far_y0),
		.far_y1   (far_y1),
		.sq_x0    (sq_x0),
		.sq_x1    (sq_x1),
		.sq_y0    (sq_y0),
		.sq_y1    (sq_y1),
		.rx2      (rx2),
		.ry2      (ry2),
		.rr       (rr),
		.inside_s5(inside_s5),
		.border_s5(border_s5)
	);

	assign m_tdata = {(OUT_TDATA_W - 2)'(0), border_s5, inside_s5};

endmodule

`default_nettype wire

>>> rtl/core/epc_cfg_regs.sv
// APB register file holding the ellipse geometry and its derived squared radii.
`timescale 1ns / 1ps
`default_nettype none

module epc_cfg_regs
	import epc_pkg::*;
#(
	parameter int COORD_WIDTH  = EPC_COORD_WIDTH,
	parameter int RADIUS_WIDTH = EPC_RADIUS_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [APB_ADDR_W-1:0]          paddr,
	input  wire logic [APB_DATA_W-1:0]          pwdata,
	output logic      [APB_DATA_W-1:0]          prdata,
	output logic signed [COORD_WIDTH-1:0]       center_x,
	output logic signed [COORD_WIDTH-1:0]       center_y,
	output logic      [RADIUS_WIDTH-1:0]        rx_eff,
	output logic      [RADIUS_WIDTH-1:0]        ry_eff,
	output logic      [2*RADIUS_WIDTH-1:0]      rx2,
	output logic      [2*RADIUS_WIDTH-1:0]      ry2,
	output logic      [4*RADIUS_WIDTH-1:0]      rr
);

	localparam int SQ_W = 2 * RADIUS_WIDTH;
	localparam int RR_W = 4 * RADIUS_WIDTH;

	logic signed [COORD_WIDTH-1:0] cx_q;
	logic signed [COORD_WIDTH-1:0] cy_q;
	logic [RADIUS_WIDTH-1:0]       rh_q;
	logic [RADIUS_WIDTH-1:0]       rv_q;
	logic [SQ_W-1:0]               rx2_q;
	logic [SQ_W-1:0]               ry2_q;
	logic [RR_W-1:0]               rr_q;
	logic                          wr_en;
	reg_idx_t                      idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			rh_q <= RADIUS_WIDTH'(1);
			rv_q <= RADIUS_WIDTH'(1);
		end else if (wr_en) begin
			case (idx)
				REG_CENTER_X:          cx_q <= pwdata[COORD_WIDTH-1:0];
				REG_CENTER_Y:          cy_q <= pwdata[COORD_WIDTH-1:0];
				REG_RADIUS_HORIZONTAL: rh_q <= pwdata[RADIUS_WIDTH-1:0];
				REG_RADIUS_VERTICAL:   rv_q <= pwdata[RADIUS_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// A zero radius is treated as one pixel.
	assign rx_eff = (rh_q == '0) ? RADIUS_WIDTH'(1) : rh_q;
	assign ry_eff = (rv_q == '0) ? RADIUS_WIDTH'(1) : rv_q;

	// Derived products are registered: the squared radii from the effective radii, then their product from the squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx2_q <= SQ_W'(1);
			ry2_q <= SQ_W'(1);
			rr_q  <= RR_W'(1);
		end else begin
			rx2_q <= SQ_W'(rx_eff) * SQ_W'(rx_eff);
			ry2_q <= SQ_W'(ry_eff) * SQ_W'(ry_eff);
			rr_q  <= RR_W'(rx2_q) * RR_W'(ry2_q);
		end
	end

	always_comb begin
		case (idx)
			REG_CENTER_X:          prdata = APB_DATA_W'(unsigned'(cx_q));
			REG_CENTER_Y:          prdata = APB_DATA_W'(unsigned'(cy_q));
			REG_RADIUS_HORIZONTAL: prdata = APB_DATA_W'(rh_q);
			REG_RADIUS_VERTICAL:   prdata = APB_DATA_W'(rv_q);
			default:               prdata = '0;
		endcase
	end

	assign center_x = cx_q;
	assign center_y = cy_q;
	assign rx2      = rx2_q;
	assign ry2      = ry2_q;
	assign rr       = rr_q;

endmodule

`default_nettype wire

>>> rtl/core/epc_pipe_ctrl.sv
// Valid bits and per-stage load enables for the five-stage classifier pipeline.
`timescale 1ns / 1ps
`default_nettype none

module epc_pipe_ctrl
	import epc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output stage_en_t en
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// A stage loads when it is empty or its contents move on, so bubbles collapse.
	assign rdy5 = !v_s5 || m_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	assign en.s1    = rdy1;
	assign en.s2    = rdy2;
	assign en.s3    = rdy3;
	assign en.s4    = rdy4;
	assign en.s5    = rdy5;
	assign s_tready = rdy1;
	assign m_tvalid = v_s5;

endmodule

`default_nettype wire

>>> rtl/core/epc_axis.sv
// One axis of the test: offset from the center, magnitude clamp and squares.
`timescale 1ns / 1ps
`default_nettype none

module epc_axis
	import epc_pkg::*;
#(
	parameter int COORD_WIDTH  = EPC_COORD_WIDTH,
	parameter int RADIUS_WIDTH = EPC_RADIUS_WIDTH
) (
	input  wire logic                        clk,
	input  wire stage_en_t                   en,
	input  wire logic signed [COORD_WIDTH-1:0] query,
	input  wire logic signed [COORD_WIDTH-1:0] center,
	input  wire logic [RADIUS_WIDTH-1:0]     radius,
	output logic                             far0_s3,
	output logic                             far1_s3,
	output logic [2*RADIUS_WIDTH-1:0]        sq0_s3,
	output logic [2*RADIUS_WIDTH-1:0]        sq1_s3
);

	localparam int DW   = COORD_WIDTH + 1;
	localparam int MW   = (DW > RADIUS_WIDTH) ? DW : RADIUS_WIDTH;
	localparam int SQ_W = 2 * RADIUS_WIDTH;

	logic signed [DW-1:0]     d_s1;
	logic [DW-1:0]            mag;
	logic [MW-1:0]            mag_ext;
	logic [MW-1:0]            rad_ext;
	logic                     far0_s2;
	logic                     far1_s2;
	logic [RADIUS_WIDTH-1:0]  a0_s2;
	logic [RADIUS_WIDTH-1:0]  a1_s2;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			d_s1 <= DW'(query) - DW'(center);
		end
	end

	assign mag     = d_s1[DW-1] ? (~unsigned'(d_s1) + DW'(1)) : unsigned'(d_s1);
	assign mag_ext = MW'(mag);
	assign rad_ext = MW'(radius);

	// The pixel and its outward neighbor are each clamped to zero once they pass the radius.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			far0_s2 <= mag_ext > rad_ext;
			far1_s2 <= mag_ext >= rad_ext;
			a0_s2   <= (mag_ext > rad_ext) ? '0 : mag_ext[RADIUS_WIDTH-1:0];
			a1_s2   <= (mag_ext >= rad_ext) ? '0
			           : mag_ext[RADIUS_WIDTH-1:0] + RADIUS_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			far0_s3 <= far0_s2;
			far1_s3 <= far1_s2;
			sq0_s3  <= SQ_W'(a0_s2) * SQ_W'(a0_s2);
			sq1_s3  <= SQ_W'(a1_s2) * SQ_W'(a1_s2);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/epc_decide.sv
// Scales the squared offsets by the opposite radius and compares against the bound.
`timescale 1ns / 1ps
`default_nettype none

module epc_decide
	import epc_pkg::*;
#(
	parameter int RADIUS_WIDTH = EPC_RADIUS_WIDTH
) (
	input  wire logic                      clk,
	input  wire stage_en_t                 en,
	input  wire logic                      far_x0,
	input  wire logic                      far_x1,
	input  wire logic                      far_y0,
	input  wire logic                      far_y1,
	input  wire logic [2*RADIUS_WIDTH-1:0] sq_x0,
	input  wire logic [2*RADIUS_WIDTH-1:0] sq_x1,
	input  wire logic [2*RADIUS_WIDTH-1:0] sq_y0,
	input  wire logic [2*RADIUS_WIDTH-1:0] sq_y1,
	input  wire logic [2*RADIUS_WIDTH-1:0] rx2,
	input  wire logic [2*RADIUS_WIDTH-1:0] ry2,
	input  wire logic [4*RADIUS_WIDTH-1:0] rr,
	output logic                           inside_s5,
	output logic                           border_s5
);

	localparam int P_W = 4 * RADIUS_WIDTH;
	localparam int S_W = P_W + 1;

	logic [P_W-1:0] px0_s4, px1_s4, py0_s4, py1_s4;
	logic           far0_s4, far1_s4;
	logic           in0, in1;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			px0_s4  <= P_W'(sq_x0) * P_W'(ry2);
			px1_s4  <= P_W'(sq_x1) * P_W'(ry2);
			py0_s4  <= P_W'(sq_y0) * P_W'(rx2);
			py1_s4  <= P_W'(sq_y1) * P_W'(rx2);
			far0_s4 <= far_x0 | far_y0;
			far1_s4 <= far_x1 | far_y1;
		end
	end

	assign in0 = !far0_s4 && ((S_W'(px0_s4) + S_W'(py0_s4)) <= S_W'(rr));
	assign in1 = !far1_s4 && ((S_W'(px1_s4) + S_W'(py1_s4)) <= S_W'(rr));

	// The diagonal neighbor further out on both axes is outside whenever any neighbor is.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			inside_s5 <= in0;
			border_s5 <= in0 && !in1;
		end
	end

endmodule

`default_nettype wire
